@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the core.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/csp_pkg.sv @@
// Types and constants of the cylinder support point core.
// No dependencies.
package csp_pkg;
    localparam int DATA_W     = 32;
    localparam int RADIUS_W   = 31;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 64;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int ROOT_W     = 32;
    localparam int SREM_W     = 33;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
    } t_point;

    // Token that walks down the chain of cells.
    typedef struct packed {
        logic              valid;
        logic              neg_x;
        logic              neg_y;
        logic              neg_z;
        logic              full_nz;
        logic              rad_nz;
        logic [SQ_W-1:0]   rad_sq;
        logic [SREM_W-1:0] srem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   prod_x;
        logic [SQ_W-1:0]   prod_z;
        logic [ROOT_W-1:0] drem_x;
        logic [ROOT_W-1:0] drem_z;
        logic [DATA_W-1:0] quot_x;
        logic [DATA_W-1:0] quot_z;
    } t_work;
endpackage

@@ rtl/core/csp_front.sv @@
// Front stages: magnitudes, squares, threshold compares and radius products.
// Depends on csp_pkg.
module csp_front import csp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_dir                i_dir,
    input  logic [RADIUS_W-1:0] i_radius,
    input  logic [THRESH_W-1:0] i_thresh,
    output t_work               o_work
);
    logic              r_a_valid, r_nx, r_ny, r_nz;
    logic [DATA_W-1:0] r_ax, r_az;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_sqz;
    logic [DATA_W-1:0] n_ax, n_ay, n_az;
    logic [SQ_W-1:0]   w_rad, w_full, w_tsq;
    t_work             r_work, n_work;

    always_comb begin
        n_ax = i_dir.dir_x[DATA_W-1] ? DATA_W'(-i_dir.dir_x) : i_dir.dir_x;
        n_ay = i_dir.dir_y[DATA_W-1] ? DATA_W'(-i_dir.dir_y) : i_dir.dir_y;
        n_az = i_dir.dir_z[DATA_W-1] ? DATA_W'(-i_dir.dir_z) : i_dir.dir_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_nx  <= i_dir.dir_x[DATA_W-1];
            r_ny  <= i_dir.dir_y[DATA_W-1];
            r_nz  <= i_dir.dir_z[DATA_W-1];
            r_ax  <= n_ax;
            r_az  <= n_az;
            r_sqx <= SQ_W'(n_ax) * SQ_W'(n_ax);
            r_sqy <= SQ_W'(n_ay) * SQ_W'(n_ay);
            r_sqz <= SQ_W'(n_az) * SQ_W'(n_az);
        end
    end

    // The three squares are each at most 2^62, so the sums cannot wrap.
    always_comb begin
        w_tsq  = SQ_W'(i_thresh) * SQ_W'(i_thresh);
        w_rad  = r_sqx + r_sqz;
        w_full = w_rad + r_sqy;
        n_work = '0;
        n_work.valid   = r_a_valid;
        n_work.neg_x   = r_nx;
        n_work.neg_y   = r_ny;
        n_work.neg_z   = r_nz;
        n_work.full_nz = w_full > w_tsq;
        n_work.rad_nz  = w_rad > w_tsq;
        n_work.rad_sq  = w_rad;
        n_work.prod_x  = SQ_W'(r_ax) * SQ_W'(i_radius);
        n_work.prod_z  = SQ_W'(r_az) * SQ_W'(i_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else if (i_en) begin
            r_work.valid <= n_work.valid;
        end
        if (i_en) begin
            r_work[$bits(t_work)-2:0] <= n_work[$bits(t_work)-2:0];
        end
    end

    assign o_work = r_work;
endmodule

@@ rtl/core/csp_root_cell.sv @@
// One digit step of the radial square root: two radicand bits in, one root bit out.
// Depends on csp_pkg.
module csp_root_cell import csp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_work i_work,
    output t_work o_work
);
    logic [SREM_W+1:0] w_rem, w_trial;
    logic              w_take;
    t_work             n_work, r_work;

    // The remainder never exceeds twice the root, so it fits in SREM_W bits.
    always_comb begin
        w_rem   = {i_work.srem, i_work.rad_sq[SQ_W-1 -: 2]};
        w_trial = {1'b0, i_work.root, 2'b01};
        w_take  = w_rem >= w_trial;
        n_work  = i_work;
        n_work.rad_sq = {i_work.rad_sq[SQ_W-3:0], 2'b00};
        n_work.srem   = w_take ? SREM_W'(w_rem - w_trial) : SREM_W'(w_rem);
        n_work.root   = {i_work.root[ROOT_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else if (i_en) begin
            r_work.valid <= n_work.valid;
        end
        if (i_en) begin
            r_work[$bits(t_work)-2:0] <= n_work[$bits(t_work)-2:0];
        end
    end

    assign o_work = r_work;
endmodule

@@ rtl/core/csp_div_cell.sv @@
// One restoring division step for both radial components, divisor is the root.
// Depends on csp_pkg.
module csp_div_cell import csp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_work i_work,
    output t_work o_work
);
    logic [ROOT_W:0] w_rx, w_rz, w_s;
    logic            w_tx, w_tz;
    t_work           n_work, r_work;

    always_comb begin
        w_s  = {1'b0, i_work.root};
        w_rx = {i_work.drem_x, i_work.prod_x[ROOT_W-1]};
        w_rz = {i_work.drem_z, i_work.prod_z[ROOT_W-1]};
        w_tx = w_rx >= w_s;
        w_tz = w_rz >= w_s;
        n_work = i_work;
        n_work.prod_x = {i_work.prod_x[SQ_W-2:0], 1'b0};
        n_work.prod_z = {i_work.prod_z[SQ_W-2:0], 1'b0};
        n_work.drem_x = w_tx ? ROOT_W'(w_rx - w_s) : ROOT_W'(w_rx);
        n_work.drem_z = w_tz ? ROOT_W'(w_rz - w_s) : ROOT_W'(w_rz);
        n_work.quot_x = {i_work.quot_x[DATA_W-2:0], w_tx};
        n_work.quot_z = {i_work.quot_z[DATA_W-2:0], w_tz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else if (i_en) begin
            r_work.valid <= n_work.valid;
        end
        if (i_en) begin
            r_work[$bits(t_work)-2:0] <= n_work[$bits(t_work)-2:0];
        end
    end

    assign o_work = r_work;
endmodule

@@ rtl/core/cylinder_support_point_core.sv @@
// Support point of an upright cylinder (axis y) for a Q16.16 direction.
// Depends on csp_pkg, csp_front, csp_root_cell, csp_div_cell, assert_macros.svh.
//
// One transfer is taken and one result leaves per cycle while the output is not stalled. An item
// passes from input to output through two front stages, a chain of 32 square
// root cells, a chain of 32 divider cells and the output register. While the
// output is stalled with a result held, the whole chain holds and input stalls.
// Configuration writes take effect at once and belong in idle periods.
`include "assert_macros.svh"
module cylinder_support_point_core import csp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_dir                 i_dir,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_point               o_point,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RADIUS_W-1:0]  i_cfg_data
);
    logic [RADIUS_W-1:0] r_radius, r_half_height;
    logic [THRESH_W-1:0] r_thresh;
    logic                w_en, r_out_valid;
    t_point              r_point, n_point;
    t_work               w_root [ROOT_STEPS+1];
    t_work               w_div  [DIV_STEPS+1];
    logic [DATA_W-1:0]   w_hh;
    logic [DATA_W-1:0]   w_abs_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_W'(65536);
            r_half_height <= RADIUS_W'(32768);
            r_thresh      <= THRESH_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS:      r_radius      <= i_cfg_data;
                REG_HALF_HEIGHT: r_half_height <= i_cfg_data;
                REG_THRESHOLD:   r_thresh      <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    csp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_dir    (i_dir),
        .i_radius (r_radius),
        .i_thresh (r_thresh),
        .o_work   (w_root[0])
    );

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        csp_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_work  (w_root[g]),
            .o_work  (w_root[g+1])
        );
    end

    // The quotient stays below 2^31, so the top half of the product is already
    // smaller than the divisor and starts as the remainder.
    always_comb begin
        w_div[0] = w_root[ROOT_STEPS];
        w_div[0].drem_x = w_root[ROOT_STEPS].prod_x[SQ_W-1 -: ROOT_W];
        w_div[0].drem_z = w_root[ROOT_STEPS].prod_z[SQ_W-1 -: ROOT_W];
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        csp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_work  (w_div[g]),
            .o_work  (w_div[g+1])
        );
    end

    always_comb begin
        w_hh    = DATA_W'(r_half_height);
        n_point = '0;
        if (w_div[DIV_STEPS].full_nz) begin
            n_point.point_y = w_div[DIV_STEPS].neg_y ? DATA_W'(-w_hh) : w_hh;
            if (w_div[DIV_STEPS].rad_nz) begin
                n_point.point_x = w_div[DIV_STEPS].neg_x ?
                    DATA_W'(-w_div[DIV_STEPS].quot_x) : w_div[DIV_STEPS].quot_x;
                n_point.point_z = w_div[DIV_STEPS].neg_z ?
                    DATA_W'(-w_div[DIV_STEPS].quot_z) : w_div[DIV_STEPS].quot_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div[DIV_STEPS].valid;
        end
        if (w_en) begin
            r_point <= n_point;
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_point;

    assign w_abs_x = o_point.point_x[DATA_W-1] ? DATA_W'(-o_point.point_x) : o_point.point_x;

    `ASSERT_CLK_ALWAYS(a_reset_clears_out, i_clk, !$past(i_rst_n) |-> !o_valid)
    `ASSERT_CLK(a_chain_holds, i_clk, i_rst_n, !w_en |=> $stable(w_div[DIV_STEPS].valid))
    `ASSERT_CLK(a_x_within_radius, i_clk, i_rst_n, o_valid |-> w_abs_x <= DATA_W'(r_radius))
endmodule
